[hw/rtl/csym_pkg.sv]
package csym_pkg;

    localparam int CFG_ADDR_W = 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CURVED_MODE    = 1'b0,
        REG_SCHWARZ_RADIUS = 1'b1
    } cfg_reg_t;

    // cordic datapath
    localparam int CW           = 34;
    localparam int CORDIC_STEPS = 31;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001
    };

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2
    } quad_t;

    // quotient bits produced by the divider before saturation
    localparam int QUO_BITS = 33;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } clamp_t;

    typedef struct packed {
        logic [31:0] r;
        logic [31:0] rs;
        logic [31:0] mdiff;
        logic        diffneg;
        logic        curved;
        logic        dneg;
        logic        dzero;
        logic        rzero;
    } rad_t;

    typedef struct packed {
        logic        vld;
        rad_t        rad;
        logic [31:0] ad;
        logic        thzero;
    } cor_tag_t;

    typedef struct packed {
        logic vld;
        logic curved;
        logic dneg;
        logic dzero;
        logic rzero;
    } rad_flags_t;

    typedef struct packed {
        logic   cotguard;
        logic   cotneg;
        clamp_t phph;
    } cot_tag_t;

    function automatic clamp_t clamp_mag(input logic [63:0] mag, input logic neg);
        clamp_t c;
        if (neg)
        begin
            c.sat = mag > 64'h8000_0000;
            c.val = c.sat ? 32'h8000_0000 : 32'(64'd0 - mag);
        end
        else
        begin
            c.sat = mag > 64'h7FFF_FFFF;
            c.val = c.sat ? 32'h7FFF_FFFF : mag[31:0];
        end
        return c;
    endfunction

    function automatic clamp_t clamp_quo(input logic [QUO_BITS:0] q, input logic big,
                                         input logic neg);
        clamp_t c;
        if (big)
        begin
            c.sat = 1'b1;
            c.val = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            c = clamp_mag(64'(q), neg);
        end
        return c;
    endfunction

endpackage

[hw/rtl/christoffel_symbol_eval.sv]
// Evaluates the nine distinct nonzero Christoffel symbols of flat spherical or
// Schwarzschild spacetime for one point (r, theta) per beat. A point is taken
// in every cycle while the output is not stalled; each result passes through
// the 33-stage sine/cosine pipeline, three multiply stages and the 34-stage
// radix-2 dividers that form 1/r, cot theta and the two curved-space terms.
// Outputs are signed fixed point with FRAC_BITS fraction bits and saturate;
// tuser flags a guarded or saturated entry. Write curved_mode and
// schwarz_radius only while no beat is in flight.
module christoffel_symbol_eval #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [csym_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [31:0]                       cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // radius [31:0], polar_angle [62:32], zero [63]
    input  logic [63:0]                       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // gamma_t_tr, gamma_r_tt, gamma_r_rr, gamma_r_thth, gamma_r_phph,
    // gamma_th_rth, gamma_th_phph, gamma_ph_rph, gamma_ph_thph (32 bits each)
    output logic [287:0]                      m_axis_tdata,
    // singular_flag
    output logic                              m_axis_tuser
);

    localparam int CW     = csym_pkg::CW;
    localparam int QB     = csym_pkg::QUO_BITS;
    localparam int PSHIFT = 60 - FRAC_BITS;
    localparam int N1_W   = 32 + 2 * FRAC_BITS;
    localparam int N2_W   = 64 + 2 * FRAC_BITS;
    localparam int N3_W   = 2 * FRAC_BITS + 1;
    localparam int N4_W   = 32 + FRAC_BITS;

    logic        en;
    logic        curved_reg;
    logic [31:0] rs_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curved_reg <= 1'b1;
            rs_reg     <= 32'd65536;
        end
        else if (cfg_wr_en)
        begin
            unique case (csym_pkg::cfg_reg_t'(cfg_addr))
                csym_pkg::REG_CURVED_MODE:    curved_reg <= cfg_wdata[0];
                csym_pkg::REG_SCHWARZ_RADIUS: rs_reg     <= cfg_wdata;
                default:                      curved_reg <= curved_reg;
            endcase
        end
    end

    // input decode
    logic [31:0]        in_r;
    logic [32:0]        in_d;
    csym_pkg::cor_tag_t in_tag;

    always_comb
    begin
        in_r               = s_axis_tdata[31:0];
        in_d               = {1'b0, in_r} - {1'b0, rs_reg};
        in_tag.vld         = s_axis_tvalid;
        in_tag.thzero      = s_axis_tdata[62:32] == 31'd0;
        in_tag.ad          = in_d[32] ? rs_reg - in_r : in_d[31:0];
        in_tag.rad.r       = in_r;
        in_tag.rad.rs      = rs_reg;
        in_tag.rad.curved  = curved_reg;
        in_tag.rad.dneg    = in_d[32];
        in_tag.rad.dzero   = in_r == rs_reg;
        in_tag.rad.rzero   = in_r == 32'd0;
        in_tag.rad.mdiff   = curved_reg ? in_tag.ad : in_r;
        in_tag.rad.diffneg = curved_reg ? (!in_d[32] && !in_tag.rad.dzero)
                                        : !in_tag.rad.rzero;
    end

    logic signed [CW-1:0] c_sn;
    logic signed [CW-1:0] c_cs;
    csym_pkg::cor_tag_t   c_tag;

    csym_cordic #(
        .TAG_W ($bits(csym_pkg::cor_tag_t))
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .theta   (s_axis_tdata[62:32]),
        .tag_in  (in_tag),
        .sn      (c_sn),
        .cs      (c_cs),
        .tag_out (c_tag)
    );

    // stage a: first products
    logic [31:0] c_ms;
    logic [31:0] c_mcs;
    logic        c_snneg;
    logic        c_csneg;

    assign c_snneg = c_sn < 0;
    assign c_csneg = c_cs < 0;
    assign c_ms    = c_snneg ? 32'(-c_sn) : 32'(c_sn);
    assign c_mcs   = c_csneg ? 32'(-c_cs) : 32'(c_cs);

    logic               a_vld_reg;
    csym_pkg::rad_t     a_rad_reg;
    logic [63:0]        a_sq_reg;
    logic [63:0]        a_pmag_reg;
    logic               a_ppos_reg;
    logic [63:0]        a_rr_reg;
    logic [63:0]        a_rsad_reg;
    logic [64:0]        a_den1_reg;
    logic               a_cotguard_reg;
    logic               a_cotneg_reg;
    logic [31:0]        a_ms_reg;
    logic [31:0]        a_mcs_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_rad_reg      <= c_tag.rad;
            a_sq_reg       <= 64'(c_ms) * 64'(c_ms);
            a_pmag_reg     <= 64'(c_ms) * 64'(c_mcs);
            a_ppos_reg     <= (c_snneg == c_csneg) && (c_ms != 32'd0) && (c_mcs != 32'd0);
            a_rr_reg       <= 64'(c_tag.rad.r) * 64'(c_tag.rad.r);
            a_rsad_reg     <= 64'(c_tag.rad.rs) * 64'(c_tag.ad);
            a_den1_reg     <= 65'({c_tag.rad.r, 1'b0}) * 65'(c_tag.ad);
            a_cotguard_reg <= c_tag.thzero || (c_ms == 32'd0);
            a_cotneg_reg   <= c_snneg != c_csneg;
            a_ms_reg       <= c_ms;
            a_mcs_reg      <= c_mcs;
        end
    end

    // stage b: sin squared, r cubed partials, direct terms
    logic               b_vld_reg;
    csym_pkg::rad_t     b_rad_reg;
    logic [32:0]        b_s2_reg;
    logic [63:0]        b_pplo_reg;
    logic [63:0]        b_pphi_reg;
    csym_pkg::clamp_t   b_thphph_reg;
    csym_pkg::clamp_t   b_thth_reg;
    logic [63:0]        b_rsad_reg;
    logic [64:0]        b_den1_reg;
    logic               b_cotguard_reg;
    logic               b_cotneg_reg;
    logic [31:0]        b_ms_reg;
    logic [31:0]        b_mcs_reg;

    logic [63:0] a_pround;
    assign a_pround = (a_pmag_reg + (64'd1 << (PSHIFT - 1))) >> PSHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_rad_reg      <= a_rad_reg;
            b_s2_reg       <= 33'((a_sq_reg + 64'd536870912) >> 30);
            b_pplo_reg     <= 64'(a_rr_reg[31:0]) * 64'(a_rad_reg.r);
            b_pphi_reg     <= 64'(a_rr_reg[63:32]) * 64'(a_rad_reg.r);
            b_thphph_reg   <= csym_pkg::clamp_mag(a_pround, a_ppos_reg);
            b_thth_reg     <= csym_pkg::clamp_mag(64'(a_rad_reg.mdiff), a_rad_reg.diffneg);
            b_rsad_reg     <= a_rsad_reg;
            b_den1_reg     <= a_den1_reg;
            b_cotguard_reg <= a_cotguard_reg;
            b_cotneg_reg   <= a_cotneg_reg;
            b_ms_reg       <= a_ms_reg;
            b_mcs_reg      <= a_mcs_reg;
        end
    end

    // stage d: r phi phi product, 2 r cubed
    logic               d_vld_reg;
    csym_pkg::rad_t     d_rad_reg;
    logic [64:0]        d_phprod_reg;
    logic [96:0]        d_den2_reg;
    csym_pkg::clamp_t   d_thphph_reg;
    csym_pkg::clamp_t   d_thth_reg;
    logic [63:0]        d_rsad_reg;
    logic [64:0]        d_den1_reg;
    logic               d_cotguard_reg;
    logic               d_cotneg_reg;
    logic [31:0]        d_ms_reg;
    logic [31:0]        d_mcs_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_rad_reg      <= b_rad_reg;
            d_phprod_reg   <= 65'(b_rad_reg.mdiff) * 65'(b_s2_reg);
            d_den2_reg     <= (97'(b_pphi_reg) << 33) + (97'(b_pplo_reg) << 1);
            d_thphph_reg   <= b_thphph_reg;
            d_thth_reg     <= b_thth_reg;
            d_rsad_reg     <= b_rsad_reg;
            d_den1_reg     <= b_den1_reg;
            d_cotguard_reg <= b_cotguard_reg;
            d_cotneg_reg   <= b_cotneg_reg;
            d_ms_reg       <= b_ms_reg;
            d_mcs_reg      <= b_mcs_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= c_tag.vld;
            b_vld_reg <= a_vld_reg;
            d_vld_reg <= b_vld_reg;
        end
    end

    // dividers
    logic [65:0]            d_phround;
    csym_pkg::rad_flags_t   t1_in;
    csym_pkg::cot_tag_t     t4_in;

    assign d_phround = (66'(d_phprod_reg) + 66'd536870912) >> 30;

    always_comb
    begin
        t1_in.vld      = d_vld_reg;
        t1_in.curved   = d_rad_reg.curved;
        t1_in.dneg     = d_rad_reg.dneg;
        t1_in.dzero    = d_rad_reg.dzero;
        t1_in.rzero    = d_rad_reg.rzero;
        t4_in.cotguard = d_cotguard_reg;
        t4_in.cotneg   = d_cotneg_reg;
        t4_in.phph     = csym_pkg::clamp_mag(d_phround[63:0], d_rad_reg.diffneg);
    end

    logic [QB:0]            q1;
    logic [QB:0]            q2;
    logic [QB:0]            q3;
    logic [QB:0]            q4;
    logic                   big1;
    logic                   big2;
    logic                   big3;
    logic                   big4;
    csym_pkg::rad_flags_t   t1;
    csym_pkg::clamp_t       t2;
    csym_pkg::clamp_t       t3;
    csym_pkg::cot_tag_t     t4;

    csym_div #(
        .NUM_W (N1_W),
        .DEN_W (65),
        .TAG_W ($bits(csym_pkg::rad_flags_t))
    ) u_div_ttr (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     (N1_W'(d_rad_reg.rs) << (2 * FRAC_BITS)),
        .den     (d_den1_reg),
        .tag_in  (t1_in),
        .quo     (q1),
        .big     (big1),
        .tag_out (t1)
    );

    csym_div #(
        .NUM_W (N2_W),
        .DEN_W (97),
        .TAG_W ($bits(csym_pkg::clamp_t))
    ) u_div_rtt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     (N2_W'(d_rsad_reg) << (2 * FRAC_BITS)),
        .den     (d_den2_reg),
        .tag_in  (d_thth_reg),
        .quo     (q2),
        .big     (big2),
        .tag_out (t2)
    );

    csym_div #(
        .NUM_W (N3_W),
        .DEN_W (32),
        .TAG_W ($bits(csym_pkg::clamp_t))
    ) u_div_invr (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     (N3_W'(1) << (2 * FRAC_BITS)),
        .den     (d_rad_reg.r),
        .tag_in  (d_thphph_reg),
        .quo     (q3),
        .big     (big3),
        .tag_out (t3)
    );

    csym_div #(
        .NUM_W (N4_W),
        .DEN_W (32),
        .TAG_W ($bits(csym_pkg::cot_tag_t))
    ) u_div_cot (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     (N4_W'(d_mcs_reg) << FRAC_BITS),
        .den     (d_ms_reg),
        .tag_in  (t4_in),
        .quo     (q4),
        .big     (big4),
        .tag_out (t4)
    );

    // guards, saturation and output register
    csym_pkg::clamp_t ttr;
    csym_pkg::clamp_t rtt;
    csym_pkg::clamp_t rrr;
    csym_pkg::clamp_t invr;
    csym_pkg::clamp_t cot;
    logic             flag;

    always_comb
    begin
        ttr  = '0;
        rtt  = '0;
        rrr  = '0;
        if (t1.curved)
        begin
            if (t1.rzero || t1.dzero)
            begin
                ttr = '{val: 32'd1, sat: 1'b1};
            end
            else
            begin
                ttr = csym_pkg::clamp_quo(q1, big1, t1.dneg);
            end
            if (t1.rzero)
            begin
                rtt = '{val: 32'd1, sat: 1'b1};
            end
            else
            begin
                rtt = csym_pkg::clamp_quo(q2, big2, t1.dneg);
            end
            if (ttr.val == 32'h8000_0000)
            begin
                rrr = '{val: 32'h7FFF_FFFF, sat: 1'b1};
            end
            else
            begin
                rrr = '{val: 32'd0 - ttr.val, sat: 1'b0};
            end
        end
        if (t1.rzero)
        begin
            invr = '{val: 32'd1, sat: 1'b1};
        end
        else
        begin
            invr = csym_pkg::clamp_quo(q3, big3, 1'b0);
        end
        if (t4.cotguard)
        begin
            cot = '{val: 32'd1, sat: 1'b1};
        end
        else
        begin
            cot = csym_pkg::clamp_quo(q4, big4, t4.cotneg);
        end
        flag = ttr.sat | rtt.sat | rrr.sat | t2.sat | t4.phph.sat | invr.sat
             | t3.sat | cot.sat;
    end

    logic         out_vld_reg;
    logic [287:0] out_data_reg;
    logic         out_flag_reg;

    assign en = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= t1.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {cot.val, invr.val, t3.val, invr.val, t4.phph.val,
                             t2.val, rrr.val, rtt.val, ttr.val};
            out_flag_reg <= flag;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flag_reg;

endmodule

[hw/rtl/csym_cordic.sv]
module csym_cordic #(
    parameter int TAG_W = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic [30:0]                        theta,
    input  logic [TAG_W-1:0]                   tag_in,
    output logic signed [csym_pkg::CW-1:0]     sn,
    output logic signed [csym_pkg::CW-1:0]     cs,
    output logic [TAG_W-1:0]                   tag_out
);

    localparam int CW = csym_pkg::CW;
    localparam int NS = csym_pkg::CORDIC_STEPS;

    logic signed [CW-1:0] x_reg [0:NS];
    logic signed [CW-1:0] y_reg [0:NS];
    logic signed [CW-1:0] z_reg [0:NS];
    csym_pkg::quad_t      quad_reg [0:NS];
    logic [TAG_W-1:0]     tag_reg [0:NS];

    logic signed [CW-1:0] sn_reg;
    logic signed [CW-1:0] cs_reg;
    logic [TAG_W-1:0]     tag_out_reg;

    // quarter-turn reduction
    logic [31:0]     u0;
    logic [31:0]     u1;
    logic [31:0]     u2;
    csym_pkg::quad_t quad0;

    always_comb
    begin
        u0    = {theta, 1'b0};
        u1    = u0;
        u2    = u0;
        quad0 = csym_pkg::QUAD_0;
        if (u0 > csym_pkg::HALF_PI_Q30)
        begin
            u1    = u0 - csym_pkg::HALF_PI_Q30;
            u2    = u1;
            quad0 = csym_pkg::QUAD_1;
            if (u1 > csym_pkg::HALF_PI_Q30)
            begin
                u2    = u1 - csym_pkg::HALF_PI_Q30;
                quad0 = csym_pkg::QUAD_2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= csym_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({2'b00, u2});
            quad_reg[0] <= quad0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_iter
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] ang;

        assign dx  = y_reg[k] >>> k;
        assign dy  = x_reg[k] >>> k;
        assign ang = $signed({2'b00, csym_pkg::ATAN_TAB[k]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[k] >= 0)
                begin
                    x_reg[k+1] <= x_reg[k] - dx;
                    y_reg[k+1] <= y_reg[k] + dy;
                    z_reg[k+1] <= z_reg[k] - ang;
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + dx;
                    y_reg[k+1] <= y_reg[k] - dy;
                    z_reg[k+1] <= z_reg[k] + ang;
                end
                quad_reg[k+1] <= quad_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k+1] <= '0;
            end
            else if (en)
            begin
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    // map back to the original quadrant
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (quad_reg[NS])
                csym_pkg::QUAD_1:
                begin
                    sn_reg <= x_reg[NS];
                    cs_reg <= -y_reg[NS];
                end
                csym_pkg::QUAD_2:
                begin
                    sn_reg <= -y_reg[NS];
                    cs_reg <= -x_reg[NS];
                end
                default:
                begin
                    sn_reg <= y_reg[NS];
                    cs_reg <= x_reg[NS];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_out_reg <= '0;
        end
        else if (en)
        begin
            tag_out_reg <= tag_reg[NS];
        end
    end

    assign sn      = sn_reg;
    assign cs      = cs_reg;
    assign tag_out = tag_out_reg;

endmodule

[hw/rtl/csym_div.sv]
module csym_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 64,
    parameter int TAG_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [NUM_W-1:0]              num,
    input  logic [DEN_W-1:0]              den,
    input  logic [TAG_W-1:0]              tag_in,
    output logic [csym_pkg::QUO_BITS:0]   quo,
    output logic                          big,
    output logic [TAG_W-1:0]              tag_out
);

    localparam int QB = csym_pkg::QUO_BITS;
    localparam int WW = (NUM_W > DEN_W + QB + 1) ? NUM_W : DEN_W + QB + 1;

    logic [WW-1:0]    rem_reg [0:QB-1];
    logic [QB-1:0]    q_reg   [0:QB-1];
    logic             big_reg [0:QB-1];
    logic [DEN_W-1:0] den_reg [0:QB-1];
    logic [TAG_W-1:0] tag_reg [0:QB-1];

    logic [QB:0]      quo_reg;
    logic             big_out_reg;
    logic [TAG_W-1:0] tag_out_reg;

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [WW-1:0]    rem_in;
        logic [QB-1:0]    q_in;
        logic             big_in;
        logic [DEN_W-1:0] den_in;
        logic [TAG_W-1:0] tag_src;
        logic [WW-1:0]    dsh;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = WW'(num);
            assign q_in    = '0;
            assign big_in  = WW'(num) >= (WW'(den) << QB);
            assign den_in  = den;
            assign tag_src = tag_in;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign big_in  = big_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign tag_src = tag_reg[k-1];
        end

        assign dsh = WW'(den_in) << (QB - 1 - k);
        assign ge  = rem_in >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? rem_in - dsh : rem_in;
                q_reg[k]   <= {q_in[QB-2:0], ge};
                big_reg[k] <= big_in;
                den_reg[k] <= den_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else if (en)
            begin
                tag_reg[k] <= tag_src;
            end
        end
    end

    // round half up on the remainder
    logic rnd;
    assign rnd = (rem_reg[QB-1] << 1) >= WW'(den_reg[QB-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg     <= {1'b0, q_reg[QB-1]} + (QB+1)'(rnd);
            big_out_reg <= big_reg[QB-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_out_reg <= '0;
        end
        else if (en)
        begin
            tag_out_reg <= tag_reg[QB-1];
        end
    end

    assign quo     = quo_reg;
    assign big     = big_out_reg;
    assign tag_out = tag_out_reg;

endmodule

[sim/christoffel_symbol_eval_checker.sv]
module christoffel_symbol_eval_checker
    import csym_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_wdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [287:0]          m_axis_tdata,
    input  logic                  m_axis_tuser,
    output int                    mismatches,
    output int                    pending
);

    typedef struct {
        logic [287:0] symbols;
        bit           singular;
    } symbol_set_t;

    symbol_set_t expected_sets[$];
    bit          model_curved;
    logic [31:0] model_rs;

    function automatic logic [31:0] sat32(logic [129:0] mag, bit neg, inout bit flag);
        if (neg)
        begin
            if (mag > 130'h8000_0000)
            begin
                flag = 1;
                return 32'h8000_0000;
            end
            return 32'(130'd0 - mag);
        end
        if (mag > 130'h7FFF_FFFF)
        begin
            flag = 1;
            return 32'h7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    function automatic logic [129:0] rnd_shift(logic [129:0] mag, int s);
        return (mag + (130'd1 << (s - 1))) >> s;
    endfunction

    function automatic logic [31:0] rnd_quotient(logic [129:0] num, logic [129:0] den,
                                                 bit neg, inout bit flag);
        logic [129:0] q;
        logic [129:0] rm;
        if (den == 0)
            return sat32({130{1'b1}}, neg, flag);
        q  = num / den;
        rm = num % den;
        if ((rm << 1) >= den)
            q = q + 1;
        return sat32(q, neg, flag);
    endfunction

    function automatic void sin_cos(logic [30:0] th, output longint sn, output longint cs);
        longint u;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        int quad;
        u = longint'(th) * 2;
        x = longint'(CORDIC_GAIN);
        y = 0;
        quad = 0;
        if (u > longint'(HALF_PI_Q30))
        begin
            u = u - longint'(HALF_PI_Q30);
            quad = 1;
        end
        if (u > longint'(HALF_PI_Q30))
        begin
            u = u - longint'(HALF_PI_Q30);
            quad = 2;
        end
        z = u;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TAB[i]);
            end
        end
        if (quad == 0)
        begin
            sn = y;
            cs = x;
        end
        else if (quad == 1)
        begin
            sn = x;
            cs = -y;
        end
        else
        begin
            sn = -y;
            cs = -x;
        end
    endfunction

    function automatic symbol_set_t eval_symbols(logic [31:0] r, logic [30:0] th);
        symbol_set_t s;
        bit flag;
        longint d;
        longint diff;
        longint sn;
        longint cs;
        longint p;
        logic [129:0] ad;
        logic [129:0] mdiff;
        logic [129:0] ms;
        logic [129:0] s2;
        logic [129:0] rr;
        logic [31:0] ttr;
        logic [31:0] rtt;
        logic [31:0] rrr;
        logic [31:0] inv_r;
        logic [31:0] cot;
        logic [31:0] thth;
        logic [31:0] phph;
        logic [31:0] thphph;
        flag = 0;
        rr = 130'(r);
        d = longint'(r) - longint'(model_rs);
        ad = 130'(d < 0 ? -d : d);
        diff = model_curved ? -d : -longint'(r);
        mdiff = 130'(diff < 0 ? -diff : diff);
        ttr = 0;
        rtt = 0;
        rrr = 0;
        if (model_curved)
        begin
            if (r == 0 || d == 0)
            begin
                ttr = 1;
                flag = 1;
            end
            else
                ttr = rnd_quotient(130'(model_rs) << 32, (rr << 1) * ad, d < 0, flag);
            if (r == 0)
            begin
                rtt = 1;
                flag = 1;
            end
            else
                rtt = rnd_quotient((130'(model_rs) * ad) << 32, (rr * rr * rr) << 1,
                                   d < 0, flag);
            if (ttr == 32'h8000_0000)
            begin
                rrr = 32'h7FFF_FFFF;
                flag = 1;
            end
            else
                rrr = -ttr;
        end
        thth = sat32(mdiff, diff < 0, flag);
        sin_cos(th, sn, cs);
        ms = 130'(sn < 0 ? -sn : sn);
        s2 = rnd_shift(ms * ms, 30);
        phph = sat32(rnd_shift(mdiff * s2, 30), diff < 0, flag);
        if (r == 0)
        begin
            inv_r = 1;
            flag = 1;
        end
        else
            inv_r = rnd_quotient(130'd1 << 32, rr, 0, flag);
        p = sn * cs;
        thphph = sat32(rnd_shift(130'(p < 0 ? -p : p), 44), p > 0, flag);
        if (th == 0 || sn == 0)
        begin
            cot = 1;
            flag = 1;
        end
        else
            cot = rnd_quotient(130'(cs < 0 ? -cs : cs) << 16, ms, (cs < 0) != (sn < 0), flag);
        s.symbols = {cot, inv_r, thphph, inv_r, phph, thth, rrr, rtt, ttr};
        s.singular = flag;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        symbol_set_t want;
        if (!rst_n)
        begin
            model_curved = 1;
            model_rs = 32'd65536;
            expected_sets.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_sets.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output beat %h flag %b", m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = expected_sets.pop_front();
                    for (int f = 0; f < 9; f++)
                    begin
                        if (m_axis_tdata[f*32 +: 32] !== want.symbols[f*32 +: 32])
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("symbol %0d: expected %h, got %h", f,
                                         want.symbols[f*32 +: 32], m_axis_tdata[f*32 +: 32]);
                        end
                    end
                    if (m_axis_tuser !== want.singular)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("singular flag: expected %b, got %b",
                                     want.singular, m_axis_tuser);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_sets.push_back(eval_symbols(s_axis_tdata[31:0], s_axis_tdata[62:32]));
            if (cfg_wr_en)
            begin
                if (cfg_addr == REG_CURVED_MODE)
                    model_curved = cfg_wdata[0];
                else if (cfg_addr == REG_SCHWARZ_RADIUS)
                    model_rs = cfg_wdata;
            end
            pending = expected_sets.size();
        end
    end

endmodule

[sim/christoffel_symbol_eval_test.sv]
module christoffel_symbol_eval_test;
    import csym_pkg::*;

    localparam int  STALL_LIMIT = 3000;
    localparam logic [30:0] THETA_PI = 31'd1686629713;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [31:0]           cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [287:0]          m_axis_tdata;
    logic                  m_axis_tuser;
    int                    mismatches;
    int                    pending;
    bit                    quiet;
    int                    idle_cycles = 0;
    logic [31:0]           cur_rs;

    christoffel_symbol_eval dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    christoffel_symbol_eval_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    task automatic send_point(logic [31:0] r, logic [30:0] th);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {1'b0, th, r};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_wr_en <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 0;
        @(posedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic random_point(int n);
        logic [31:0] r;
        logic [30:0] th;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 5))
                0: r = $urandom_range(0, 255);
                1: r = cur_rs + $urandom_range(0, 8) - 4;
                2: r = $urandom;
                3: r = $urandom >> $urandom_range(0, 31);
                4: r = 32'hFFFF_FFFF - $urandom_range(0, 1000);
                default: r = $urandom_range(1 << 14, 1 << 22);
            endcase
            case ($urandom_range(0, 7))
                0: th = 31'($urandom_range(0, 3));
                1: th = 31'($urandom);
                2: th = 31'(THETA_PI - $urandom_range(0, 3));
                default: th = 31'($urandom_range(0, THETA_PI));
            endcase
            send_point(r, th);
        end
    endtask

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("christoffel_symbol_eval_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        int beats;
        int stall;
        beats = 0;
        m_axis_tready <= 0;
        wait (rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 5);
            if (beats == 150)
                stall = 400;
            if (stall > 0)
            begin
                m_axis_tready <= 0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1;
            do @(posedge clk); while (!m_axis_tvalid);
            beats++;
        end
    end

    initial
    begin
        quiet         = 0;
        cur_rs        = 32'd65536;
        rst_n         <= 0;
        cfg_wr_en     <= 0;
        cfg_addr      <= REG_CURVED_MODE;
        cfg_wdata     <= 0;
        s_axis_tvalid <= 0;
        s_axis_tdata  <= 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset settings: curved, rs = 1.0
        send_point(32'd0, 31'd0);
        send_point(32'd65536, THETA_PI >> 1);
        send_point(32'hFFFF_FFFF, THETA_PI);
        send_point(32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_point(32'd1, 31'd1);
        send_point(32'd65535, 31'd843314856);
        send_point(32'd65537, 31'd843314857);
        send_point(32'h8000_0000, 31'h4000_0000);
        send_point(32'h5555_5555, 31'h2AAA_AAAA);
        send_point(32'hAAAA_AAAA, 31'h5555_5555);
        send_point(32'd2, 31'd100);
        send_point(32'd131072, THETA_PI - 31'd1);
        random_point(60);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0: cur_rs = $urandom;
                1: cur_rs = 0;
                2: cur_rs = 32'hFFFF_FFFF;
                3: cur_rs = $urandom_range(1, 1 << 20);
                4: cur_rs = 32'd65536;
                default: cur_rs = $urandom_range(1 << 12, 1 << 18);
            endcase
            write_reg(REG_CURVED_MODE, (ph == 0 || ph == 4) ? 32'd0 : 32'd1);
            write_reg(REG_SCHWARZ_RADIUS, cur_rs);
            if (ph == 1 || ph == 2)
                send_point(cur_rs, THETA_PI >> 1);
            random_point(90);
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("christoffel_symbol_eval_test: done, clean");
        else
            $display("christoffel_symbol_eval_test: done, errors");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/csym_pkg.sv
hw/rtl/csym_cordic.sv
hw/rtl/csym_div.sv
hw/rtl/christoffel_symbol_eval.sv
sim/christoffel_symbol_eval_checker.sv
sim/christoffel_symbol_eval_test.sv
